// ===== rtl/core/bounded_sorted_insert_list_assert.svh =====
// Assertion macros used by the sorted insert list top module.
`ifndef BOUNDED_SORTED_INSERT_LIST_ASSERT_SVH
`define BOUNDED_SORTED_INSERT_LIST_ASSERT_SVH

// A condition that must hold at every clock edge outside reset.
`define BSIL_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// A trigger in one cycle implies a result in the next cycle.
`define BSIL_ASSERT_NEXT(label, trig, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/bsil_pkg.sv =====
// Types and constants of the bounded sorted insert list.
package bsil_pkg;

  localparam int COUNT_W = 7;
  localparam int INDEX_W = 6;
  localparam int CMD_W   = 2;

  // Command codes carried in the input tuser.
  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ   = 2'd2;

  // One stored observation record.
  typedef struct packed {
    logic        [15:0] similarity;
    logic signed [31:0] z;
    logic signed [31:0] y;
    logic signed [31:0] x;
    logic        [9:0]  camera;
    logic        [31:0] key;
  } rec_t;

  // Broadcast control from the top level to every cell.
  typedef struct packed {
    logic               insert;
    logic [COUNT_W-1:0] count;
  } cell_ctl_t;

  // Status that a cell reports and hands to its neighbor.
  typedef struct packed {
    logic le;   // slot is occupied and its key is not above the new key
    logic hit;  // new record lands in this slot
  } cell_stat_t;

endpackage

// ===== rtl/core/bounded_sorted_insert_list.sv =====
// An accepted input transaction goes straight into the output register, and every cell
// compares and shifts in that same cycle; one transaction per cycle unless m_tready stalls.
// A read selects one cell through an OR tree over CAPACITY cells.
// Reset (rst, synchronous) clears the fill count and the output valid flag.
// Record storage has no reset; only slots below the fill count are ever read.
module bounded_sorted_insert_list
  import bsil_pkg::*;
#(
  parameter int CAPACITY = 10
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // pix_size_key[31:0], camera_id[41:32], point_x[73:42], point_y[105:74],
  // point_z[137:106], similarity[153:138], read_index[159:154]
  input  logic [159:0] s_tdata,
  // cmd[1:0]
  input  logic [1:0]   s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // out_key[31:0], out_camera[41:32], out_x[73:42], out_y[105:74], out_z[137:106],
  // out_similarity[153:138], entry_count[160:154], insert_position[167:161]
  output logic [167:0] m_tdata,
  // accepted[0], read_valid[1]
  output logic [1:0]   m_tuser
);

  `include "bounded_sorted_insert_list_assert.svh"

  localparam logic [COUNT_W-1:0] CAP = COUNT_W'(CAPACITY);

  logic               in_fire;
  logic [CMD_W-1:0]   cmd;
  logic [INDEX_W-1:0] read_index;
  rec_t               new_rec;
  cell_ctl_t          ctl;
  logic [COUNT_W-1:0] count;
  logic [COUNT_W-1:0] count_next;
  rec_t               cell_rec  [CAPACITY];
  cell_stat_t         cell_stat [CAPACITY];
  logic [CAPACITY-1:0] hit_vec;
  logic               any_hit;
  logic [COUNT_W-1:0] pos;
  logic               rd_valid;
  rec_t               rd_rec;
  logic               is_insert;
  logic               is_read;

  // Unpack the input transaction.
  assign cmd                = s_tuser;
  assign new_rec.key        = s_tdata[31:0];
  assign new_rec.camera     = s_tdata[41:32];
  assign new_rec.x          = s_tdata[73:42];
  assign new_rec.y          = s_tdata[105:74];
  assign new_rec.z          = s_tdata[137:106];
  assign new_rec.similarity = s_tdata[153:138];
  assign read_index         = s_tdata[159:154];

  // A new transaction is taken whenever the output register is free or drains.
  assign s_tready  = !m_tvalid || m_tready;
  assign in_fire   = s_tvalid && s_tready;
  assign is_insert = cmd == CMD_INSERT;
  assign is_read   = cmd == CMD_READ;

  assign ctl.insert = in_fire && is_insert;
  assign ctl.count  = count;

  // Chain of cells, each fed by its left neighbor.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    if (i == 0) begin : g_head
      bsil_cell #(.INDEX(i)) u_cell (
        .clk      (clk),
        .ctl      (ctl),
        .new_rec  (new_rec),
        .prev_rec (new_rec),
        .prev_le  (1'b1),
        .rec      (cell_rec[i]),
        .stat     (cell_stat[i])
      );
    end else begin : g_body
      bsil_cell #(.INDEX(i)) u_cell (
        .clk      (clk),
        .ctl      (ctl),
        .new_rec  (new_rec),
        .prev_rec (cell_rec[i-1]),
        .prev_le  (cell_stat[i-1].le),
        .rec      (cell_rec[i]),
        .stat     (cell_stat[i])
      );
    end
    assign hit_vec[i] = cell_stat[i].hit;
  end

  assign any_hit  = |hit_vec;
  assign rd_valid = {1'b0, read_index} < count;

  // Encode the landing slot and select the read record.
  always_comb begin
    pos    = '0;
    rd_rec = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (hit_vec[i]) begin
        pos = pos | COUNT_W'(i);
      end
      if ({1'b0, read_index} == COUNT_W'(i)) begin
        rd_rec = rd_rec | cell_rec[i];
      end
    end
    if (!any_hit) begin
      pos = CAP;
    end
  end

  // Fill count update.
  always_comb begin
    count_next = count;
    if (in_fire) begin
      if (is_insert && any_hit && count < CAP) begin
        count_next = count + COUNT_W'(1);
      end else if (cmd == CMD_CLEAR) begin
        count_next = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s_tready) begin
      m_tvalid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      m_tdata[153:0]   <= (is_read && rd_valid) ?
                          {rd_rec.similarity, rd_rec.z, rd_rec.y, rd_rec.x,
                           rd_rec.camera, rd_rec.key} : 154'd0;
      m_tdata[160:154] <= count_next;
      m_tdata[167:161] <= is_insert ? pos : CAP;
      m_tuser[0]       <= is_insert && any_hit;
      m_tuser[1]       <= is_read && rd_valid;
    end
  end

  `BSIL_ASSERT_ALWAYS(a_count_bound, count <= CAP, "fill count above capacity")
  `BSIL_ASSERT_ALWAYS(a_hit_onehot, $onehot0(hit_vec), "more than one landing slot")
  `BSIL_ASSERT_NEXT(a_count_grows, ctl.insert && any_hit && count < CAP,
                    count == $past(count) + COUNT_W'(1), "insert did not grow the list")
  `BSIL_ASSERT_NEXT(a_clear_empties, in_fire && cmd == CMD_CLEAR, count == '0,
                    "clear did not empty the list")

endmodule

// ===== rtl/core/bsil_cell.sv =====
// One slot of the sorted list: holds a record, compares and shifts.
module bsil_cell
  import bsil_pkg::*;
#(
  parameter int INDEX = 0
) (
  input  logic       clk,
  input  cell_ctl_t  ctl,
  input  rec_t       new_rec,
  input  rec_t       prev_rec,
  input  logic       prev_le,
  output rec_t       rec,
  output cell_stat_t stat
);

  logic occupied;

  // The slot is valid when its index is below the fill count.
  assign occupied = ctl.count > COUNT_W'(INDEX);
  assign stat.le  = occupied && (rec.key <= new_rec.key);
  assign stat.hit = prev_le && !stat.le;

  // On an insert the landing slot takes the new record and later slots shift.
  always_ff @(posedge clk) begin
    if (ctl.insert) begin
      if (stat.hit) begin
        rec <= new_rec;
      end else if (!prev_le) begin
        rec <= prev_rec;
      end
    end
  end

endmodule
